// ===== design/akl_pkg.sv =====
// Package: shared types and constants of the keep-alive link monitor.
`default_nettype none
package akl_pkg;
  localparam int unsigned NumRegs = 8;

  typedef enum logic [2:0] {
    KindTick    = 3'd0,
    KindResp    = 3'd1,
    KindTimeout = 3'd2,
    KindClear   = 3'd3,
    KindStart   = 3'd4,
    KindStop    = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    RegAdapt = 3'd0,
    RegBase  = 3'd1,
    RegExc   = 3'd2,
    RegGood  = 3'd3,
    RegFair  = 3'd4,
    RegPoor  = 3'd5,
    RegMin   = 3'd6,
    RegMax   = 3'd7
  } reg_e;

  localparam logic [15:0] FastTime      = 16'd100;
  localparam logic [15:0] FastAvg       = 16'd150;
  localparam logic [15:0] SlowTime      = 16'd2000;
  localparam logic [15:0] SlowAvg       = 16'd1500;
  localparam logic [15:0] FloorInterval = 16'd1000;
  localparam logic [15:0] ResetInterval = 16'd6000;
  localparam logic [1:0]  SlowSteps     = 2'd3;
  localparam logic [1:0]  QualGood      = 2'd1;
  localparam logic [1:0]  QualPoor      = 2'd3;

  typedef struct packed {
    logic        start;
    logic [21:0] dividend;
    logic [6:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== design/akl_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module akl_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ===== design/akl_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module akl_div (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  akl_pkg::div_req_t     req_i,
  output akl_pkg::div_rsp_t     rsp_o
);
  import akl_pkg::*;

  logic [21:0] quo_q, quo_d;
  logic [6:0]  den_q;
  logic [7:0]  rem_q, rem_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [7:0]  trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[6:0], quo_q[21]};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      cnt_d  = 5'd21;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[20:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[20:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (req_i.start) begin
      den_q <= req_i.divisor;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q[15:0];
endmodule
`default_nettype wire

// ===== design/adaptive_keepalive_link_monitor.sv =====
// Top level: adaptive keep-alive link monitor.
// Usage:
//  - Input channel (in_valid_i / in_stall_o) carries one event beat: kind_i
//    and response_time_i. Output channel (out_valid_o / out_stall_i) gives one
//    status beat per event.
//  - Configuration: cfg_we_i, cfg_index_i, cfg_data_i; write while idle only.
//    Every write re-evaluates the interval on the following cycle.
//  - Sequence: a response's status beat passes the history RAM read, the
//    RAM write with the divider start, a 22-step serial divider for the
//    average, adaptation and the interval update before it is valid; other
//    events pass only the interval update before their beat is valid.
//    One event at a time; the next can be taken the cycle after the status
//    beat leaves.
//  - The output beat sits in a register; a new event is not taken until it
//    has been taken by the receiver, so a stall simply holds it.
//  - Reset: registers to their defaults, quality good, interval 6000, timer
//    stopped, history empty. The history RAM needs no clearing: the fill
//    count guards every read.
`default_nettype none
module adaptive_keepalive_link_monitor #(
  parameter int unsigned History     = 16,
  parameter int unsigned MissedLimit = 3
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [15:0] response_time_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             send_keepalive_o,
  output logic             unhealthy_o,
  output logic [1:0]       quality_level_o,
  output logic             quality_changed_o,
  output logic [15:0]      interval_ms_o,
  output logic             interval_changed_o,
  output logic [15:0]      average_time_o,
  output logic [7:0]       missed_count_o,
  output logic [15:0]      success_count_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import akl_pkg::*;

  localparam int unsigned HAw = (History > 1) ? $clog2(History) : 1;
  localparam int unsigned FAw = $clog2(History + 1);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StRead  = 7'b0000010,
    StSum   = 7'b0000100,
    StDiv   = 7'b0001000,
    StAdapt = 7'b0010000,
    StIntv  = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic        adapt_q;
  logic [15:0] regs_q [1:7];

  // link state
  logic [1:0]  qual_q, old_q_q;
  logic [15:0] intv_q, old_i_q, cnt_q;
  logic        run_q;
  logic [7:0]  missed_q;
  logic [15:0] succ_q;
  logic [1:0]  slow_q;
  logic [FAw-1:0] fill_q;
  logic [HAw-1:0] head_q;
  logic [21:0] sum_q;
  logic [15:0] avg_q;
  logic [2:0]  kind_q;
  logic [15:0] t_q;
  logic        send_q, bad_q;
  logic        cfg_pend_q;

  // history RAM
  logic        ram_we;
  logic [15:0] ram_rdata;

  akl_ram #(.Width(16), .Depth(1 << HAw)) u_hist (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (head_q),
    .wdata_i(t_q),
    .rdata_o(ram_rdata)
  );

  div_req_t div_req;
  div_rsp_t div_rsp;

  akl_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // interval selection from current quality, or from the base interval when adaptation is off
  logic [15:0] lo, hi, sel, intv_new;
  always_comb begin
    lo  = (regs_q[RegMin] < FloorInterval) ? FloorInterval : regs_q[RegMin];
    hi  = (regs_q[RegMax] < lo) ? lo : regs_q[RegMax];
    sel = adapt_q ? regs_q[3'd2 + {1'b0, qual_q}] : regs_q[RegBase];
    intv_new = sel;
    if (intv_new > hi) intv_new = hi;
    if (intv_new < lo) intv_new = lo;
  end

  logic full;
  assign full = (fill_q >= FAw'(History));

  logic fast, slow;
  assign fast = (t_q < FastTime) && (avg_q < FastAvg);
  assign slow = (t_q > SlowTime) || (avg_q > SlowAvg);

  logic accept;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle) || out_valid_o || cfg_pend_q;
  assign ram_we     = (state_q == StSum);

  always_comb begin
    div_req.start    = (state_q == StSum);
    div_req.dividend = full ? (sum_q - {6'd0, ram_rdata} + {6'd0, t_q})
                            : (sum_q + {6'd0, t_q});
    div_req.divisor  = 7'(full ? fill_q : fill_q + FAw'(1));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (accept) state_d = (kind_i == KindResp) ? StRead : StIntv;
      StRead:  state_d = StSum;
      StSum:   state_d = StDiv;
      StDiv:   if (div_rsp.done) state_d = StAdapt;
      StAdapt: state_d = StIntv;
      StIntv:  state_d = StOut;
      StOut:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      adapt_q     <= 1'b1;
      regs_q[1]   <= 16'd6000;
      regs_q[2]   <= 16'd9000;
      regs_q[3]   <= 16'd6000;
      regs_q[4]   <= 16'd4000;
      regs_q[5]   <= 16'd2000;
      regs_q[6]   <= 16'd1000;
      regs_q[7]   <= 16'd30000;
      qual_q      <= QualGood;
      old_q_q     <= QualGood;
      intv_q      <= ResetInterval;
      old_i_q     <= ResetInterval;
      cnt_q       <= '0;
      run_q       <= 1'b0;
      missed_q    <= '0;
      succ_q      <= '0;
      slow_q      <= '0;
      fill_q      <= '0;
      head_q      <= '0;
      sum_q       <= '0;
      avg_q       <= '0;
      out_valid_o <= 1'b0;
      cfg_pend_q  <= 1'b0;
      kind_q      <= KindTick;
      t_q         <= '0;
      send_q      <= 1'b0;
      bad_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      cfg_pend_q <= 1'b0;
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;

      if (cfg_we_i) begin
        cfg_pend_q <= 1'b1;
        if (cfg_index_i == RegAdapt) adapt_q <= cfg_data_i[0];
        else regs_q[cfg_index_i] <= cfg_data_i;
      end
      // interval refresh after a configuration write
      if (cfg_pend_q && intv_new != intv_q) begin
        intv_q <= intv_new;
        if (run_q) cnt_q <= intv_new;
      end

      case (state_q)
        StIdle: begin
          if (accept) begin
            kind_q  <= kind_i;
            t_q     <= response_time_i;
            old_q_q <= qual_q;
            old_i_q <= intv_q;
            send_q  <= 1'b0;
            bad_q   <= 1'b0;
            case (kind_i)
              KindTick: begin
                if (run_q) begin
                  if (cnt_q <= 16'd1) begin
                    send_q <= 1'b1;
                    cnt_q  <= intv_q;
                  end else begin
                    cnt_q <= cnt_q - 16'd1;
                  end
                end
              end
              KindResp: begin
                if (succ_q != 16'hFFFF) succ_q <= succ_q + 16'd1;
                missed_q <= '0;
              end
              KindTimeout: begin
                if (missed_q != 8'hFF) missed_q <= missed_q + 8'd1;
                if ((missed_q == 8'hFF ? 9'h0FF : {1'b0, missed_q} + 9'd1)
                    >= 9'(MissedLimit)) begin
                  bad_q <= 1'b1;
                  if (adapt_q && qual_q != QualPoor) qual_q <= qual_q + 2'd1;
                end
              end
              KindClear: begin
                missed_q <= '0;
                succ_q   <= '0;
                fill_q   <= '0;
                head_q   <= '0;
                sum_q    <= '0;
                avg_q    <= '0;
                slow_q   <= '0;
                qual_q   <= QualGood;
              end
              KindStart: begin
                if (!run_q) begin
                  run_q <= 1'b1;
                  cnt_q <= intv_q;
                end
              end
              KindStop: run_q <= 1'b0;
              default: ;
            endcase
          end
        end
        StSum: begin
          sum_q <= div_req.dividend;
          if (!full) fill_q <= fill_q + FAw'(1);
          head_q <= (head_q == HAw'(History - 1)) ? '0 : head_q + HAw'(1);
        end
        StDiv: if (div_rsp.done) avg_q <= div_rsp.quotient;
        StAdapt: begin
          if (adapt_q) begin
            if (fast) begin
              if (qual_q == 2'd1 && succ_q > 16'd5) qual_q <= 2'd0;
              else if (qual_q == 2'd2 && succ_q > 16'd3) qual_q <= 2'd1;
              else if (qual_q == 2'd3 && succ_q > 16'd2) qual_q <= 2'd2;
            end else if (slow) begin
              if (slow_q + 2'd1 >= SlowSteps) begin
                slow_q <= '0;
                if (qual_q != QualPoor) qual_q <= qual_q + 2'd1;
              end else begin
                slow_q <= slow_q + 2'd1;
              end
            end else begin
              slow_q <= '0;
            end
          end
        end
        StIntv: begin
          // interval follows quality after any change (or clear)
          if ((qual_q != old_q_q || kind_q == KindClear) && intv_new != intv_q
              && (adapt_q || kind_q == KindClear)) begin
            intv_q <= intv_new;
            if (run_q) cnt_q <= intv_new;
          end
        end
        StOut: out_valid_o <= 1'b1;
        default: ;
      endcase
    end
  end

  assign send_keepalive_o   = send_q;
  assign unhealthy_o        = bad_q;
  assign quality_level_o    = qual_q;
  assign quality_changed_o  = (qual_q != old_q_q);
  assign interval_ms_o      = intv_q;
  assign interval_changed_o = (intv_q != old_i_q);
  assign average_time_o     = avg_q;
  assign missed_count_o     = missed_q;
  assign success_count_o    = succ_q;

  // assertions
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !accept) else $error("beat taken while busy");
  a_out_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == StIdle) else $error("result while working");
  a_interval_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> intv_q >= FloorInterval) else $error("interval below floor");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FAw'(History)) else $error("history overfilled");
endmodule
`default_nettype wire

// ===== verif/adaptive_keepalive_link_monitor_test.sv =====
// Testbench: directed and random event beats for the keep-alive link monitor.
`timescale 1ns / 100ps
module adaptive_keepalive_link_monitor_test;
  import akl_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam logic [2:0] KindUnused6 = 3'd6;
  localparam logic [2:0] KindUnused7 = 3'd7;

  // one status beat
  typedef struct {
    bit          send;
    bit          bad;
    logic [1:0]  qual;
    bit          qual_chg;
    logic [15:0] interval;
    bit          int_chg;
    logic [15:0] avg;
    logic [7:0]  missed;
    logic [15:0] succ;
  } status_t;

  // directed row; typed expectations are checked only where chk is set
  typedef struct {
    logic [2:0]  kind;
    logic [15:0] rt;
    bit          chk;
    logic [1:0]  qual;
    logic [15:0] interval;
    logic [7:0]  missed;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  kind_i = KindTick;
  logic [15:0] response_time_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        send_keepalive_o, unhealthy_o, quality_changed_o, interval_changed_o;
  logic [1:0]  quality_level_o;
  logic [15:0] interval_ms_o, average_time_o, success_count_o;
  logic [7:0]  missed_count_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = RegAdapt;
  logic [15:0] cfg_data_i = '0;

  adaptive_keepalive_link_monitor dut (.*);

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor: a cycle-free model of the monitor's state
  // ---------------------------------------------------------------------------
  int unsigned regs[8];
  int unsigned qual, cur_int, cdown, missed, succ, slow, fill, head, hsum, avg_ms;
  bit          running;
  int unsigned hist[16];

  status_t status_q[$];
  int unsigned errors, beats_in, beats_out, keepalives, unhealthy_seen, qual_moves;
  int unsigned cycles;
  bit          no_idle;

  function automatic void recompute_interval();
    int unsigned lo, hi, v;
    lo = regs[RegMin] < FloorInterval ? FloorInterval : regs[RegMin];
    hi = regs[RegMax] < lo ? lo : regs[RegMax];
    v  = regs[RegAdapt] ? regs[RegExc + qual] : regs[RegBase];
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    if (v != cur_int) begin
      cur_int = v;
      if (running) cdown = v;
    end
  endfunction

  function automatic void set_quality(int unsigned q);
    if (q == qual) return;
    qual = q;
    if (regs[RegAdapt]) recompute_interval();
  endfunction

  function automatic void step_down();
    if (qual < QualPoor) set_quality(qual + 1);
  endfunction

  function automatic void reset_state();
    regs = '{1, 6000, 9000, 6000, 4000, 2000, 1000, 30000};
    qual = QualGood; cur_int = ResetInterval; cdown = 0; running = 0;
    missed = 0; succ = 0; slow = 0; fill = 0; head = 0; hsum = 0; avg_ms = 0;
    recompute_interval();
  endfunction

  function automatic void note_response(int unsigned t);
    if (succ < 65535) succ++;
    missed = 0;
    // moving average over the last 16 round trips
    if (fill >= 16) hsum -= hist[head];
    else fill++;
    hist[head] = t;
    hsum += t;
    head = (head + 1) % 16;
    avg_ms = hsum / fill;
    if (!regs[RegAdapt]) return;
    if (t < FastTime && avg_ms < FastAvg) begin
      if (qual == 1 && succ > 5) set_quality(0);
      else if (qual == 2 && succ > 3) set_quality(1);
      else if (qual == 3 && succ > 2) set_quality(2);
    end else if (t > SlowTime || avg_ms > SlowAvg) begin
      slow++;
      if (slow >= SlowSteps) begin
        step_down();
        slow = 0;
      end
    end else begin
      slow = 0;
    end
  endfunction

  function automatic status_t predict_status(logic [2:0] kind, logic [15:0] rt);
    status_t s;
    int unsigned old_q, old_i;
    old_q = qual; old_i = cur_int;
    s.send = 0; s.bad = 0;
    case (kind)
      KindTick: begin
        if (running) begin
          if (cdown <= 1) begin
            s.send = 1;
            cdown = cur_int;
          end else begin
            cdown--;
          end
        end
      end
      KindResp: note_response(rt);
      KindTimeout: begin
        if (missed < 255) missed++;
        if (missed >= 3) begin
          s.bad = 1;
          if (regs[RegAdapt]) step_down();
        end
      end
      KindClear: begin
        missed = 0; succ = 0; fill = 0; head = 0; hsum = 0; avg_ms = 0; slow = 0;
        qual = QualGood;
        recompute_interval();
      end
      KindStart: begin
        if (!running) begin
          running = 1;
          cdown = cur_int;
        end
      end
      KindStop: running = 0;
      default: ;
    endcase
    s.qual = qual[1:0];
    s.qual_chg = qual != old_q;
    s.interval = cur_int[15:0];
    s.int_chg = cur_int != old_i;
    s.avg = avg_ms[15:0];
    s.missed = missed[7:0];
    s.succ = succ[15:0];
    return s;
  endfunction

  task automatic report(string what, int got, int want);
    $display("MISMATCH beat %0d %s: got %0d, expected %0d", beats_out, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender side: gap draw, then hold the beat until the block takes it
  // ---------------------------------------------------------------------------
  task automatic send_event(logic [2:0] kind, logic [15:0] rt, output status_t s);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    kind_i <= kind;
    response_time_i <= rt;
    do @(posedge clk_i); while (in_stall_o);
    s = predict_status(kind, rt);
    status_q.push_back(s);
    beats_in++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (status_q.size() == 0);
    // quiet cycles so the block is fully idle
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    regs[idx] = idx == RegAdapt ? value[0] : value;
    recompute_interval();
    // the block re-evaluates the interval the cycle after a write
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_rt();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 99));
      1: return 16'($urandom_range(100, 2000));
      2: return 16'($urandom_range(2001, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  // random traffic; tick_pct sets how tick-heavy the mix is
  task automatic run_random(int n, int tick_pct, bit allow_stop);
    status_t s;
    int r, i;
    logic [2:0] k;
    i = 0;
    while (i < n) begin
      if (i % 150 == 0) no_idle = $urandom_range(0, 3) == 0;
      r = $urandom_range(0, 99);
      if (r < tick_pct) begin
        send_event(KindTick, 16'($urandom), s);
        i++;
      end else if ($urandom_range(0, 9) == 0) begin
        // burst of fast round trips so the quality can climb
        repeat (8) send_event(KindResp, 16'($urandom_range(0, 99)), s);
        i += 8;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) k = KindResp;
        else if (r < 72) k = KindTimeout;
        else if (r < 84) k = KindStart;
        else if (r < 90) k = allow_stop ? KindStop : KindStart;
        else if (r < 95) k = allow_stop ? KindClear : KindResp;
        else k = $urandom_range(0, 1) ? KindUnused6 : KindUnused7;
        send_event(k, k == KindResp ? pick_rt() : logic'($urandom) ? 16'hFFFF : 16'h0000, s);
        i++;
      end
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls per beat, one long hold-off
  // ---------------------------------------------------------------------------
  int hold;
  bit long_done;
  initial begin
    hold = 0;
    long_done = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // check each accepted beat against the oldest prediction
  always @(posedge clk_i) begin
    status_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (status_q.size() == 0) begin
        $display("MISMATCH status beat with nothing expected");
        errors++;
      end else begin
        e = status_q.pop_front();
        if (send_keepalive_o !== e.send) report("send_keepalive", send_keepalive_o, e.send);
        if (unhealthy_o !== e.bad) report("unhealthy", unhealthy_o, e.bad);
        if (quality_level_o !== e.qual) report("quality_level", quality_level_o, e.qual);
        if (quality_changed_o !== e.qual_chg)
          report("quality_changed", quality_changed_o, e.qual_chg);
        if (interval_ms_o !== e.interval) report("interval_ms", interval_ms_o, e.interval);
        if (interval_changed_o !== e.int_chg)
          report("interval_changed", interval_changed_o, e.int_chg);
        if (average_time_o !== e.avg) report("average_time", average_time_o, e.avg);
        if (missed_count_o !== e.missed) report("missed_count", missed_count_o, e.missed);
        if (success_count_o !== e.succ) report("success_count", success_count_o, e.succ);
        keepalives += e.send;
        unhealthy_seen += e.bad;
        qual_moves += e.qual_chg;
      end
      beats_out++;
      // after some traffic, hold off long enough for the input to back up
      if (!long_done && beats_out == 120) begin
        hold = 300;
        long_done = 1;
      end else if (!no_idle) begin
        hold = $urandom_range(0, 7);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles, status_q.size());
      $display("adaptive_keepalive_link_monitor_test NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table, default registers
  // ---------------------------------------------------------------------------
  row_t rows[] = '{
    '{KindTick,    16'd0,     1, 2'd1, 16'd6000, 8'd0},  // tick while stopped
    '{KindStop,    16'd0,     1, 2'd1, 16'd6000, 8'd0},  // stop while stopped
    '{KindStart,   16'd0,     0, 0, 0, 0},
    '{KindStart,   16'd0,     0, 0, 0, 0},               // start while running
    '{KindTick,    16'hFFFF,  0, 0, 0, 0},
    '{KindTimeout, 16'd0,     1, 2'd1, 16'd6000, 8'd1},
    '{KindTimeout, 16'd0,     1, 2'd1, 16'd6000, 8'd2},
    '{KindTimeout, 16'd0,     1, 2'd2, 16'd4000, 8'd3},  // missed limit, step down
    '{KindResp,    16'd0,     1, 2'd2, 16'd4000, 8'd0},
    '{KindResp,    16'hFFFF,  0, 0, 0, 0},               // slow by time
    '{KindResp,    16'hFFFF,  0, 0, 0, 0},
    '{KindResp,    16'd3000,  1, 2'd3, 16'd2000, 8'd0},  // third slow in a row
    '{KindClear,   16'd0,     1, 2'd1, 16'd6000, 8'd0},
    '{KindUnused6, 16'hFFFF,  1, 2'd1, 16'd6000, 8'd0},
    '{KindUnused7, 16'd0,     1, 2'd1, 16'd6000, 8'd0},
    '{KindResp,    16'd50,    0, 0, 0, 0},
    '{KindResp,    16'd50,    0, 0, 0, 0},
    '{KindResp,    16'd50,    0, 0, 0, 0},
    '{KindResp,    16'd50,    0, 0, 0, 0},
    '{KindResp,    16'd50,    0, 0, 0, 0},
    '{KindResp,    16'd99,    1, 2'd0, 16'd9000, 8'd0},  // fast run: up to excellent
    '{KindResp,    16'd100,   0, 0, 0, 0},               // neither fast nor slow
    '{KindTick,    16'd0,     0, 0, 0, 0},
    '{KindStop,    16'd0,     0, 0, 0, 0},
    '{KindClear,   16'd0,     1, 2'd1, 16'd6000, 8'd0}
  };

  initial begin
    status_t s;
    errors = 0; beats_in = 0; beats_out = 0; cycles = 0;
    keepalives = 0; unhealthy_seen = 0; qual_moves = 0; no_idle = 0;
    reset_state();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(negedge clk_i);

    foreach (rows[i]) begin
      send_event(rows[i].kind, rows[i].rt, s);
      if (rows[i].chk) begin
        if (s.qual != rows[i].qual) report("row quality", s.qual, rows[i].qual);
        if (s.interval != rows[i].interval) report("row interval", s.interval, rows[i].interval);
        if (s.missed != rows[i].missed) report("row missed", s.missed, rows[i].missed);
      end
    end
    drain();

    // default registers, general mix
    run_random(300, 35, 1);

    // adaptation off, shortest interval, tick-heavy traffic with the timer running
    write_reg(RegAdapt, 16'd0);
    write_reg(RegBase, 16'd1000);
    write_reg(RegMin, 16'd1000);
    write_reg(RegMax, 16'd1000);
    send_event(KindStart, 16'd0, s);
    run_random(700, 97, 0);

    // clamp extremes: min below the floor, max at the top of the field
    write_reg(RegAdapt, 16'd1);
    write_reg(RegExc, 16'hFFFF);
    write_reg(RegGood, 16'd0);
    write_reg(RegFair, 16'd60000);
    write_reg(RegPoor, 16'd1000);
    write_reg(RegMin, 16'd0);
    write_reg(RegMax, 16'hFFFF);
    run_random(300, 35, 1);

    // max below min: the min wins
    write_reg(RegMin, 16'd60000);
    write_reg(RegMax, 16'd1000);
    run_random(150, 35, 1);

    // random register set
    write_reg(RegAdapt, 16'($urandom));
    write_reg(RegBase, 16'($urandom_range(1000, 60000)));
    write_reg(RegExc, 16'($urandom_range(1000, 60000)));
    write_reg(RegGood, 16'($urandom_range(1000, 60000)));
    write_reg(RegFair, 16'($urandom_range(1000, 60000)));
    write_reg(RegPoor, 16'($urandom_range(1000, 60000)));
    write_reg(RegMin, 16'($urandom_range(1000, 5000)));
    write_reg(RegMax, 16'($urandom_range(1000, 60000)));
    run_random(300, 35, 1);

    repeat (40) @(negedge clk_i);
    $display("Covered %0d event beats over five register settings, one long receiver hold-off.",
             beats_in);
    $display("Saw %0d keep-alive requests, %0d unhealthy timeouts, %0d quality moves.",
             keepalives, unhealthy_seen, qual_moves);
    if (errors == 0 && status_q.size() == 0) begin
      $display("adaptive_keepalive_link_monitor_test OK");
    end else begin
      $display("adaptive_keepalive_link_monitor_test NOT OK");
    end
    $finish;
  end
endmodule
